// File: hw/rtl/bcdm_pkg.sv
// Shared types, constants and table functions for the beat clock divider and multiplier.
// No dependencies; every other file of the block imports this package.

package bcdm_pkg;

  localparam int unsigned TIME_W   = 28;
  localparam int unsigned PHASE_W  = 30;
  localparam int unsigned SEL_W    = 4;
  localparam int unsigned TICK_W   = 11;   // widest period is 48 * 24 = 1152
  localparam int unsigned TWIDTH_W = 8;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [PHASE_W-1:0] PHASE_MAX      = {PHASE_W{1'b1}};
  localparam logic [TIME_W-1:0]  PERIOD_RESET   = TIME_W'(44739243);
  localparam logic [TWIDTH_W-1:0] TWIDTH_RESET  = TWIDTH_W'(1);
  localparam logic [TICK_W-1:0]  BEAT_TICKS     = TICK_W'(48);
  localparam logic [TICK_W-1:0]  ORIGINAL_WIDTH = TICK_W'(48 >> 1);
  localparam logic [SEL_W-1:0]   SELECT_TOP     = SEL_W'(10);
  localparam logic [SEL_W-1:0]   SELECT_RESET   = SEL_W'(5);

  typedef enum logic [MODE_W-1:0] {
    TRIG_MODE_TRIGGER  = 2'd0,
    TRIG_MODE_GATE     = 2'd1,
    TRIG_MODE_ORIGINAL = 2'd2
  } trig_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MASTER_PERIOD = 2'd0,
    CFG_PULSE_MODE    = 2'd1,
    CFG_TRIGGER_WIDTH = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic [TIME_W-1:0] sample_time;
    logic [SEL_W-1:0]  select_b;
    logic [SEL_W-1:0]  select_c;
  } in_item_t;

  typedef struct packed {
    logic gate_a;
    logic gate_b;
    logic gate_c;
  } out_item_t;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [TWIDTH_W-1:0] width;
  } pulse_cfg_t;

  function automatic logic [SEL_W-1:0] clamp_select(input logic [SEL_W-1:0] sel);
    return (sel > SELECT_TOP) ? SELECT_TOP : sel;
  endfunction

  // Period of clock B in master ticks, index already clamped.
  function automatic logic [TICK_W-1:0] ratio_b(input logic [SEL_W-1:0] sel);
    logic [TICK_W-1:0] t;
    case (sel)
      4'd0:    t = TICK_W'(48 * 8);
      4'd1:    t = TICK_W'(48 * 6);
      4'd2:    t = TICK_W'(48 * 4);
      4'd3:    t = TICK_W'(48 * 3);
      4'd4:    t = TICK_W'(48 * 2);
      4'd5:    t = TICK_W'(48);
      4'd6:    t = TICK_W'(48 / 2);
      4'd7:    t = TICK_W'(48 / 3);
      4'd8:    t = TICK_W'(48 / 4);
      4'd9:    t = TICK_W'(48 / 6);
      default: t = TICK_W'(48 / 8);
    endcase
    return t;
  endfunction

  // Period of clock C in master ticks, index already clamped.
  function automatic logic [TICK_W-1:0] ratio_c(input logic [SEL_W-1:0] sel);
    logic [TICK_W-1:0] t;
    case (sel)
      4'd0:    t = TICK_W'(48 * 24);
      4'd1:    t = TICK_W'(48 * 12);
      4'd2:    t = TICK_W'(48 * 8);
      4'd3:    t = TICK_W'(48 * 4);
      4'd4:    t = TICK_W'(48 * 2);
      4'd5:    t = TICK_W'(48);
      4'd6:    t = TICK_W'(48 / 2);
      4'd7:    t = TICK_W'(48 / 4);
      4'd8:    t = TICK_W'(48 / 8);
      4'd9:    t = TICK_W'(48 / 12);
      default: t = TICK_W'(48 / 24);
    endcase
    return t;
  endfunction

  // Pulse width: min(mode limit, half period); gate mode is the half period itself.
  function automatic logic [TICK_W-1:0] pulse_width(input logic [TICK_W-1:0] ticks,
                                                    input pulse_cfg_t cfg);
    logic [TICK_W-1:0] half;
    logic [TICK_W-1:0] lim;
    half = ticks >> 1;
    case (cfg.mode)
      TRIG_MODE_GATE:     lim = half;
      TRIG_MODE_ORIGINAL: lim = ORIGINAL_WIDTH;
      default:            lim = TICK_W'(cfg.width);
    endcase
    return (lim < half) ? lim : half;
  endfunction

endpackage

// File: hw/rtl/bcdm_phase.sv
// Master phase accumulator: adds elapsed time, saturates, and raises one master tick
// when the phase passes the master period. Depends on bcdm_pkg.

module bcdm_phase
  import bcdm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              update_i,
  input  logic [TIME_W-1:0] sample_time_i,
  input  logic [TIME_W-1:0] period_i,
  output logic              tick_o
);

  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [PHASE_W:0]   sum;
  logic [PHASE_W-1:0] sat;

  always_comb begin
    sum    = {1'b0, phase_q} + (PHASE_W + 1)'(sample_time_i);
    sat    = sum[PHASE_W] ? PHASE_MAX : sum[PHASE_W-1:0];
    tick_o = sat > PHASE_W'(period_i);
    phase_d = tick_o ? (sat - PHASE_W'(period_i)) : sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (update_i) begin
      phase_q <= phase_d;
    end
  end

endmodule

// File: hw/rtl/bcdm_clock.sv
// One derived clock: period counter and output level, stepped on master ticks,
// with an optional phase resync. Depends on bcdm_pkg.

module bcdm_clock
  import bcdm_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              resync_i,
  input  logic [TICK_W-1:0] ticks_i,
  input  pulse_cfg_t        pulse_cfg_i,
  output logic              level_o,
  output logic              rise_o
);

  logic [COUNT_BITS-1:0] count_q, count_d, count_base, count_inc;
  logic                  level_q, level_d, level_base;
  logic [TICK_W-1:0]     width;

  always_comb begin
    width      = pulse_width(ticks_i, pulse_cfg_i);
    // Resync loads all ones so the increment lands on zero with the level held high.
    count_base = resync_i ? {COUNT_BITS{1'b1}} : count_q;
    level_base = resync_i ? 1'b1 : level_q;
    count_inc  = count_base + COUNT_BITS'(1);
    count_d    = count_inc;
    level_d    = level_base;
    rise_o     = 1'b0;
    if (count_inc >= COUNT_BITS'(width)) begin
      level_d = 1'b0;
    end
    if (count_inc >= COUNT_BITS'(ticks_i)) begin
      count_d = '0;
      level_d = 1'b1;
      rise_o  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      level_q <= 1'b0;
    end else if (step_i) begin
      count_q <= count_d;
      level_q <= level_d;
    end
  end

  assign level_o = level_d;

endmodule

// File: hw/rtl/beat_clock_divider_multiplier_unit.sv
// Top level of the beat clock divider and multiplier.
// Depends on bcdm_pkg, bcdm_phase and bcdm_clock.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i): one request per audio
//   sample tick, carrying the elapsed time and the B and C ratio selections.
//   Output channel (out_valid_o / out_stall_i / out_data_o): one request per
//   input request, holding the three gate levels after that tick.
//   Config channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i):
//   writes master_period, the pulse mode and trigger_width; always ready.
//   Write it only while no request is in flight.
// Pipeline: the input register loads at the accepting edge and the result
//   register when the request steps, which an output stall can hold off.
//   Throughput: one request per cycle unless stalled; the phase add/compare
//   and the three counter steps all fit in the single pass between registers.
// Stall: the result register holds while out_stall_i is high; the input
//   register still takes one more request, after which in_stall_o rises.
// Reset: rst_ni clears all phase, counter, level and resync state, loads the
//   default registers and empties both pipeline registers. No clearing pass.

module beat_clock_divider_multiplier_unit
  import bcdm_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [TIME_W-1:0]    cfg_data_i
);

  // Configuration registers.
  logic [TIME_W-1:0] period_q;
  pulse_cfg_t        pulse_cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q          <= PERIOD_RESET;
      pulse_cfg_q.mode  <= TRIG_MODE_ORIGINAL;
      pulse_cfg_q.width <= TWIDTH_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MASTER_PERIOD: period_q          <= cfg_data_i;
        CFG_PULSE_MODE:    pulse_cfg_q.mode  <= cfg_data_i[MODE_W-1:0];
        CFG_TRIGGER_WIDTH: pulse_cfg_q.width <= cfg_data_i[TWIDTH_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Pipeline handshake: the input register advances whenever the result
  // register is empty or being drained this cycle.
  logic     in_valid_q;
  in_item_t in_item_q;
  logic     out_free;
  logic     step;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign in_stall_o = in_valid_q && !out_free;
  assign step       = in_valid_q && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_item_q <= in_data_i;
    end
  end

  // Selection tracking: a changed (clamped) index marks its clock for resync.
  logic [SEL_W-1:0] sel_b, sel_c;
  logic [SEL_W-1:0] prior_b_q, prior_c_q;
  logic             pend_b_q, pend_c_q;
  logic             pend_b, pend_c;

  assign sel_b  = clamp_select(in_item_q.select_b);
  assign sel_c  = clamp_select(in_item_q.select_c);
  assign pend_b = pend_b_q || (sel_b != prior_b_q);
  assign pend_c = pend_c_q || (sel_c != prior_c_q);

  // Master tick.
  logic master_tick;

  bcdm_phase u_phase (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .update_i      (step),
    .sample_time_i (in_item_q.sample_time),
    .period_i      (period_q),
    .tick_o        (master_tick)
  );

  // Clock A first; its rising edge carries out any pending resync of B and C
  // before they step on the same master tick.
  logic clk_step;
  logic level_a, level_b, level_c;
  logic rise_a;
  logic resync_b, resync_c;

  assign clk_step = step && master_tick;
  assign resync_b = rise_a && pend_b;
  assign resync_c = rise_a && pend_c;

  bcdm_clock #(.COUNT_BITS(COUNT_BITS)) u_clock_a (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (clk_step),
    .resync_i    (1'b0),
    .ticks_i     (BEAT_TICKS),
    .pulse_cfg_i (pulse_cfg_q),
    .level_o     (level_a),
    .rise_o      (rise_a)
  );

  // Only clock A's rise drives the resync, so B and C leave theirs open.
  bcdm_clock #(.COUNT_BITS(COUNT_BITS)) u_clock_b (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (clk_step),
    .resync_i    (resync_b),
    .ticks_i     (ratio_b(sel_b)),
    .pulse_cfg_i (pulse_cfg_q),
    .level_o     (level_b),
    .rise_o      ()
  );

  bcdm_clock #(.COUNT_BITS(COUNT_BITS)) u_clock_c (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (clk_step),
    .resync_i    (resync_c),
    .ticks_i     (ratio_c(sel_c)),
    .pulse_cfg_i (pulse_cfg_q),
    .level_o     (level_c),
    .rise_o      ()
  );

  // Levels seen by the result: stepped values on a master tick, held otherwise.
  logic level_a_q, level_b_q, level_c_q;
  logic gate_a, gate_b, gate_c;

  assign gate_a = master_tick ? level_a : level_a_q;
  assign gate_b = master_tick ? level_b : level_b_q;
  assign gate_c = master_tick ? level_c : level_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_b_q <= SELECT_RESET;
      prior_c_q <= SELECT_RESET;
      pend_b_q  <= 1'b0;
      pend_c_q  <= 1'b0;
      level_a_q <= 1'b0;
      level_b_q <= 1'b0;
      level_c_q <= 1'b0;
    end else if (step) begin
      prior_b_q <= sel_b;
      prior_c_q <= sel_c;
      // Clear a pending resync only when clock A actually rose on a tick.
      pend_b_q  <= pend_b && !(master_tick && resync_b);
      pend_c_q  <= pend_c && !(master_tick && resync_c);
      level_a_q <= gate_a;
      level_b_q <= gate_b;
      level_c_q <= gate_c;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_free) begin
      out_valid_o <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_o.gate_a <= gate_a;
      out_data_o.gate_b <= gate_b;
      out_data_o.gate_c <= gate_c;
    end
  end

endmodule

// File: tb/sv/beat_clock_divider_multiplier_unit_tb.sv
// Self-checking testbench for beat_clock_divider_multiplier_unit: random and directed
// sample-tick requests against a cycle-free predictor of the three gate clocks.
// Depends on bcdm_pkg and the block's RTL only.

module beat_clock_divider_multiplier_unit_tb;
  import bcdm_pkg::*;

  localparam int unsigned CNT_W       = 16;
  localparam int unsigned CLK_PERIOD  = 8;
  localparam int unsigned STALL_LIMIT = 3000;  // longest legal quiet stretch is the hold-off
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned MAX_REPORTS = 10;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  // Mode code the block leaves unused; it behaves like trigger mode.
  localparam logic [MODE_W-1:0] TRIG_MODE_UNUSED = 2'd3;
  // Clock indexes inside the predictor.
  localparam int CLK_A = 0;
  localparam int CLK_B = 1;
  localparam int CLK_C = 2;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_item_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_item_t            out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [TIME_W-1:0]    cfg_data_i  = '0;

  beat_clock_divider_multiplier_unit #(
    .COUNT_BITS(CNT_W)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Requests waiting to be offered, and gate levels waiting to come out.
  in_item_t  request_q[$];
  out_item_t gate_expect_q[$];

  int unsigned mismatch_cnt = 0;
  int unsigned idle_cycles  = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          req_taken = 1'b0;
  bit          hold_go   = 1'b0;
  logic        long_hold = 1'b0;

  // Predictor copy of the registers, written alongside each register write.
  logic [TIME_W-1:0]   cur_period = PERIOD_RESET;
  logic [MODE_W-1:0]   cur_mode   = TRIG_MODE_ORIGINAL;
  logic [TWIDTH_W-1:0] cur_width  = TWIDTH_RESET;

  // Predictor copy of the clock state.
  logic [PHASE_W-1:0] phase_acc  = '0;
  logic [CNT_W-1:0]   clk_count [3];
  logic               clk_level [3];
  logic [SEL_W-1:0]   prev_sel_b = SELECT_RESET;
  logic [SEL_W-1:0]   prev_sel_c = SELECT_RESET;
  logic               resync_b   = 1'b0;
  logic               resync_c   = 1'b0;

  // Selections that the well-formed random requests keep between changes.
  logic [SEL_W-1:0] gen_sel_b = SELECT_RESET;
  logic [SEL_W-1:0] gen_sel_c = SELECT_RESET;

  function automatic int unsigned b_ticks(logic [SEL_W-1:0] sel);
    case (sel)
      4'd0:    return 48 * 8;
      4'd1:    return 48 * 6;
      4'd2:    return 48 * 4;
      4'd3:    return 48 * 3;
      4'd4:    return 48 * 2;
      4'd5:    return 48;
      4'd6:    return 48 / 2;
      4'd7:    return 48 / 3;
      4'd8:    return 48 / 4;
      4'd9:    return 48 / 6;
      default: return 48 / 8;
    endcase
  endfunction

  function automatic int unsigned c_ticks(logic [SEL_W-1:0] sel);
    case (sel)
      4'd0:    return 48 * 24;
      4'd1:    return 48 * 12;
      4'd2:    return 48 * 8;
      4'd3:    return 48 * 4;
      4'd4:    return 48 * 2;
      4'd5:    return 48;
      4'd6:    return 48 / 2;
      4'd7:    return 48 / 4;
      4'd8:    return 48 / 8;
      4'd9:    return 48 / 12;
      default: return 48 / 24;
    endcase
  endfunction

  // High time of a clock in master ticks: never more than half its period.
  function automatic int unsigned high_ticks(int unsigned ticks);
    int unsigned half;
    int unsigned lim;
    half = ticks / 2;
    if (cur_mode == TRIG_MODE_GATE) return half;
    lim = (cur_mode == TRIG_MODE_ORIGINAL) ? 24 : int'(cur_width);
    return (lim < half) ? lim : half;
  endfunction

  // Step one clock by a master tick; return 1 when it starts a new period.
  function automatic bit advance_clock(int idx, int unsigned ticks);
    int unsigned w;
    w = high_ticks(ticks);
    clk_count[idx] = clk_count[idx] + 1'b1;
    if (clk_count[idx] >= w) clk_level[idx] = 1'b0;
    if (clk_count[idx] > ticks - 1) begin
      clk_count[idx] = '0;
      clk_level[idx] = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Gate levels after one sample tick; updates the predictor state.
  function automatic out_item_t predict_gates(in_item_t req);
    logic [SEL_W-1:0] sb;
    logic [SEL_W-1:0] sc;
    logic [31:0]      sum;
    out_item_t        res;
    sb = (req.select_b > SELECT_TOP) ? SELECT_TOP : req.select_b;
    sc = (req.select_c > SELECT_TOP) ? SELECT_TOP : req.select_c;
    if (sb != prev_sel_b) begin
      prev_sel_b = sb;
      resync_b   = 1'b1;
    end
    if (sc != prev_sel_c) begin
      prev_sel_c = sc;
      resync_c   = 1'b1;
    end
    sum = 32'(phase_acc) + 32'(req.sample_time);
    phase_acc = (sum > 32'(PHASE_MAX)) ? PHASE_MAX : sum[PHASE_W-1:0];
    if (phase_acc > PHASE_W'(cur_period)) begin
      phase_acc = phase_acc - PHASE_W'(cur_period);
      // Realign pending clocks when A starts its period, before B and C step.
      if (advance_clock(CLK_A, 48)) begin
        if (resync_b) begin
          clk_count[CLK_B] = '1;
          clk_level[CLK_B] = 1'b1;
          resync_b = 1'b0;
        end
        if (resync_c) begin
          clk_count[CLK_C] = '1;
          clk_level[CLK_C] = 1'b1;
          resync_c = 1'b0;
        end
      end
      void'(advance_clock(CLK_B, b_ticks(sb)));
      void'(advance_clock(CLK_C, c_ticks(sc)));
    end
    res.gate_a = clk_level[CLK_A];
    res.gate_b = clk_level[CLK_B];
    res.gate_c = clk_level[CLK_C];
    return res;
  endfunction

  // Mostly well-formed ticks: held selections and a step sized to reach the master period.
  // The rest is noise on every field.
  function automatic in_item_t random_request();
    in_item_t    req;
    int unsigned p;
    int unsigned hi;
    p  = cur_period;
    hi = (2 * p > TIME_MAX) ? TIME_MAX : 2 * p;
    if ($urandom_range(99) < 12) begin
      req.sample_time = TIME_W'($urandom());
      req.select_b    = SEL_W'($urandom_range(15));
      req.select_c    = SEL_W'($urandom_range(15));
    end else begin
      if ($urandom_range(99) < 7) gen_sel_b = SEL_W'($urandom_range(15));
      if ($urandom_range(99) < 7) gen_sel_c = SEL_W'($urandom_range(15));
      if ($urandom_range(99) < 80) req.sample_time = TIME_W'($urandom_range(hi, p));
      else req.sample_time = TIME_W'($urandom_range(p));
      req.select_b = gen_sel_b;
      req.select_c = gen_sel_c;
    end
    return req;
  endfunction

  task automatic push_request(logic [TIME_W-1:0] dt, logic [SEL_W-1:0] sb,
                              logic [SEL_W-1:0] sc);
    in_item_t req;
    req.sample_time = dt;
    req.select_b    = sb;
    req.select_c    = sc;
    request_q.push_back(req);
  endtask

  // Write one register; update the predictor copy on the handshake edge.
  task automatic write_reg(cfg_index_e idx, logic [TIME_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MASTER_PERIOD: cur_period = data;
      CFG_PULSE_MODE:    cur_mode   = data[MODE_W-1:0];
      CFG_TRIGGER_WIDTH: cur_width  = data[TWIDTH_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(logic [TIME_W-1:0] period, logic [MODE_W-1:0] mode,
                           logic [TWIDTH_W-1:0] width);
    write_reg(CFG_MASTER_PERIOD, period);
    write_reg(CFG_PULSE_MODE, TIME_W'(mode));
    write_reg(CFG_TRIGGER_WIDTH, TIME_W'(width));
  endtask

  // Block until every queued request went in and every result came out.
  task automatic wait_drained();
    while (request_q.size() != 0 || gate_expect_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic run_random_phase(int n, int unsigned snd_pct, int unsigned rcv_pct);
    @(posedge clk_i);
    send_idle_pct  = snd_pct;
    recv_stall_pct = rcv_pct;
    repeat (n) request_q.push_back(random_request());
    wait_drained();
  endtask

  // Request driver: hold a stalled request, else offer the next one or idle.
  always @(negedge clk_i) begin : request_driver
    if (!in_valid_i || req_taken) begin
      if (rst_ni && request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i  <= request_q[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    req_taken = 1'b0;
  end

  // Result receiver: stall at random, and for the whole hold-off stretch.
  always @(negedge clk_i) begin : result_receiver
    out_stall_i <= long_hold || ($urandom_range(99) < recv_stall_pct);
  end

  // Hold-off: stop draining results long enough for the block to back up.
  initial begin : receiver_hold
    @(posedge hold_go);
    @(negedge clk_i);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    long_hold <= 1'b0;
  end

  // Monitor: check each result against the oldest expectation, and predict
  // each accepted request.
  always @(posedge clk_i) begin : gate_monitor
    out_item_t want;
    bit        moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (gate_expect_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("unexpected result a=%b b=%b c=%b", out_data_o.gate_a,
                     out_data_o.gate_b, out_data_o.gate_c);
        end else begin
          want = gate_expect_q.pop_front();
          if (out_data_o.gate_a !== want.gate_a || out_data_o.gate_b !== want.gate_b ||
              out_data_o.gate_c !== want.gate_c) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display("gate mismatch: expected a=%b b=%b c=%b, got a=%b b=%b c=%b",
                       want.gate_a, want.gate_b, want.gate_c, out_data_o.gate_a,
                       out_data_o.gate_b, out_data_o.gate_c);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        gate_expect_q.push_back(predict_gates(in_data_i));
        request_q.delete(0);
        req_taken = 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) moved = 1'b1;
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("[beat_clock_divider_multiplier_unit] ERROR");
    $finish;
  end

  initial begin : stimulus
    for (int i = 0; i < 3; i++) begin
      clk_count[i] = '0;
      clk_level[i] = 1'b0;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Defaults: no tick on zero time, full-scale steps, selection changes,
    // and indexes above the top that clamp to the same selection.
    push_request('0, 4'd5, 4'd5);
    push_request(TIME_MAX, 4'd5, 4'd5);
    push_request(TIME_MAX, 4'd0, 4'd0);
    push_request(TIME_MAX, 4'd15, 4'd15);
    push_request(TIME_MAX, 4'd11, 4'd12);
    push_request(TIME_W'(PERIOD_RESET), 4'd10, 4'd10);
    push_request(TIME_W'(1), 4'd10, 4'd10);
    wait_drained();

    // Period of one in gate mode: full-scale steps drive the phase into saturation.
    configure(TIME_W'(1), TRIG_MODE_GATE, 8'd255);
    repeat (6) push_request(TIME_MAX, 4'd10, 4'd10);
    push_request('0, 4'd10, 4'd10);
    wait_drained();

    // Zero period, unused mode code and zero width: a tick on every nonzero phase.
    configure('0, TRIG_MODE_UNUSED, 8'd0);
    push_request('0, 4'd10, 4'd10);
    push_request('0, 4'd0, 4'd0);
    push_request(TIME_W'(1), 4'd10, 4'd10);
    push_request('0, 4'd7, 4'd3);
    wait_drained();

    // Largest period in trigger mode.
    configure(TIME_MAX, TRIG_MODE_TRIGGER, 8'd0);
    push_request(TIME_MAX, 4'd3, 4'd7);
    push_request(TIME_MAX, 4'd3, 4'd7);
    push_request(TIME_MAX, 4'd3, 4'd7);
    wait_drained();

    // Random phases: each one rewrites every register and changes the idling.
    configure(TIME_W'(1000), TRIG_MODE_TRIGGER, 8'd3);
    run_random_phase(70, 0, 0);
    configure(TIME_MAX, TRIG_MODE_ORIGINAL, 8'd255);
    run_random_phase(70, 78, 0);
    configure(TIME_W'(1), TRIG_MODE_GATE, 8'd0);
    run_random_phase(70, 0, 78);
    configure(TIME_W'($urandom_range(5000, 2)), TRIG_MODE_UNUSED,
              TWIDTH_W'($urandom_range(255)));
    run_random_phase(70, 8, 8);

    // Back-pressure: keep offering requests while the receiver holds off.
    configure(TIME_W'(PERIOD_RESET), TRIG_MODE_TRIGGER, 8'd255);
    hold_go = 1'b1;
    run_random_phase(70, 0, 0);

    configure(TIME_W'(1 << 20), TRIG_MODE_ORIGINAL, TWIDTH_W'($urandom_range(255, 1)));
    run_random_phase(70, 0, 0);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && gate_expect_q.size() == 0) begin
      $display("[beat_clock_divider_multiplier_unit] OK");
    end else begin
      $display("[beat_clock_divider_multiplier_unit] ERROR");
    end
    $finish;
  end

endmodule
